@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/pdfm_pkg.sv @@
// ----------------------------------------------------------------------------
// pdfm_pkg
// Field widths, constants and shared types of the pulse duty/frequency meter.
// ----------------------------------------------------------------------------
package pdfm_pkg;

  localparam int TPS_W   = 24;
  localparam int TICKS_W = 16;
  localparam int DUTY_W  = 7;
  localparam int FREQ_W  = 24;
  localparam int PERCENT = 100;

  localparam logic [TPS_W-1:0] TPS_RESET = 24'd100000;

  // status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/pdfm_if.sv @@
// ----------------------------------------------------------------------------
// pdfm_if
// Valid/ready channels of the meter: sample input, record output, config.
// ----------------------------------------------------------------------------
interface pdfm_in_if;
  logic valid;
  logic ready;
  logic pin_level;
  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface pdfm_out_if;
  logic                            valid;
  logic                            ready;
  logic [pdfm_pkg::TICKS_W-1:0]    high_ticks;
  logic [pdfm_pkg::TICKS_W-1:0]    low_ticks;
  logic [pdfm_pkg::DUTY_W-1:0]     duty_percent;
  logic [pdfm_pkg::FREQ_W-1:0]     frequency;
  modport source (output valid, output high_ticks, output low_ticks,
                  output duty_percent, output frequency, input ready);
  modport sink   (input valid, input high_ticks, input low_ticks,
                  input duty_percent, input frequency, output ready);
endinterface

interface pdfm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pdfm_pkg::TPS_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/pulse_duty_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// pulse_duty_frequency_meter
// Measures high and low phase lengths of a sampled pin, reports duty and
// frequency once per completed period.
// ----------------------------------------------------------------------------
// Sequence: a sample that completes no period only updates the counters; a rising
//   edge runs the one bit-serial divider (NW = max(24, COUNT_WIDTH+7) bits) for
//   duty, then for frequency, and its record then enters the output register.
// Throughput: one sample per cycle between edges; in_ch.ready stays low from
//   a rising edge until its record enters the output register, which waits
//   while an earlier record there has not been taken.
// Reset: synchronous active-low rst_n clears counters, sequencer and output
//   valid, and sets ticks_per_second to 100000.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_duty_frequency_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  pdfm_in_if.sink             in_ch,
  pdfm_out_if.source          out_ch,
  pdfm_cfg_if.sink            cfg_ch
);

  localparam int CW = COUNT_WIDTH;
  localparam int NW = (CW + 7 > pdfm_pkg::TPS_W) ? CW + 7 : pdfm_pkg::TPS_W;
  localparam int DW = CW + 1;
  localparam int WW = (CW > pdfm_pkg::TICKS_W) ? CW : pdfm_pkg::TICKS_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DUTY = 2'd1;
  localparam logic [1:0] ST_FREQ = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [pdfm_pkg::TPS_W-1:0]     tps_r;
  logic [CW-1:0]                  hl_r, lo_r;
  logic                           pz_r;
  logic [pdfm_pkg::DUTY_W-1:0]    duty_r, duty_nxt;
  logic [pdfm_pkg::FREQ_W-1:0]    freq_r, freq_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [pdfm_pkg::TICKS_W-1:0]   out_high_r, out_low_r;
  logic [pdfm_pkg::DUTY_W-1:0]    out_duty_r;
  logic [pdfm_pkg::FREQ_W-1:0]    out_freq_r;

  logic                           in_acc;
  logic                           emit;
  logic [CW-1:0]                  high_done, low_done;
  logic [DW-1:0]                  period_c;
  logic [DW-1:0]                  div_den;
  logic                           div_start;
  logic [NW-1:0]                  div_num;
  logic [NW-1:0]                  div_quot;
  pdfm_pkg::div_stat_t            div_st;
  logic                           load_out;
  logic [WW-1:0]                  hl_ext, lo_ext;
  logic [pdfm_pkg::TICKS_W-1:0]   hl_sat, lo_sat;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  pdfm_phase #(.CW(CW)) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .level     (in_ch.pin_level),
    .emit      (emit),
    .high_done (high_done),
    .low_done  (low_done)
  );

  // start duty on the edge, frequency as soon as duty is done
  assign period_c  = DW'(high_done) + DW'(low_done);
  assign div_start = (in_acc && emit) || ((state_r == ST_DUTY) && div_st.done);
  assign div_num   = (state_r == ST_IDLE) ?
                     NW'(high_done) * NW'(pdfm_pkg::PERCENT) : NW'(tps_r);
  // the phase counters have moved on by then, so take the held period
  assign div_den   = (state_r == ST_IDLE) ? period_c : DW'(hl_r) + DW'(lo_r);

  pdfm_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .st    (div_st)
  );

  // clamp reported phase lengths to the field width
  assign hl_ext = WW'(hl_r);
  assign lo_ext = WW'(lo_r);
  assign hl_sat = (hl_ext > WW'({pdfm_pkg::TICKS_W{1'b1}})) ? '1 : hl_ext[pdfm_pkg::TICKS_W-1:0];
  assign lo_sat = (lo_ext > WW'({pdfm_pkg::TICKS_W{1'b1}})) ? '1 : lo_ext[pdfm_pkg::TICKS_W-1:0];

  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // sequence the two divisions and the hand-off to the output register
  always_comb begin
    state_nxt     = state_r;
    duty_nxt      = duty_r;
    freq_nxt      = freq_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc && emit) begin
          state_nxt = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (div_st.done) begin
          duty_nxt  = pz_r ? '0 : div_quot[pdfm_pkg::DUTY_W-1:0];
          state_nxt = ST_FREQ;
        end
      end
      ST_FREQ: begin
        if (div_st.done) begin
          freq_nxt  = pz_r ? '0 : div_quot[pdfm_pkg::FREQ_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tps_r       <= pdfm_pkg::TPS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tps_r <= cfg_ch.data;
      end
    end
  end

  // hold the finished phase lengths and the results
  always_ff @(posedge clk) begin
    duty_r <= duty_nxt;
    freq_r <= freq_nxt;
    if (in_acc && emit) begin
      hl_r <= high_done;
      lo_r <= low_done;
      pz_r <= (period_c == '0);
    end
    if (load_out) begin
      out_high_r <= hl_sat;
      out_low_r  <= lo_sat;
      out_duty_r <= duty_r;
      out_freq_r <= freq_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.high_ticks   = out_high_r;
  assign out_ch.low_ticks    = out_low_r;
  assign out_ch.duty_percent = out_duty_r;
  assign out_ch.frequency    = out_freq_r;

  `ASSERT_IMP(a_start_idle, clk, rst_n, div_start, !div_st.busy)
  `ASSERT_IMP(a_done_in_div, clk, rst_n, div_st.done, (state_r == ST_DUTY) || (state_r == ST_FREQ))
  `ASSERT_NXT(a_edge_starts, clk, rst_n, in_acc && emit, (state_r == ST_DUTY) && div_st.busy)
  `ASSERT_IMP(a_duty_range, clk, rst_n, state_r == ST_FREQ, duty_r <= pdfm_pkg::DUTY_W'(pdfm_pkg::PERCENT))

endmodule

@@ src/pdfm_phase.sv @@
// ----------------------------------------------------------------------------
// pdfm_phase
// Saturating high/low phase counters with edge detection on each sample.
// ----------------------------------------------------------------------------
module pdfm_phase #(
  parameter int CW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          level,
  output logic          emit,
  output logic [CW-1:0] high_done,
  output logic [CW-1:0] low_done
);

  logic [CW-1:0] high_cnt_r, high_cnt_nxt;
  logic [CW-1:0] low_cnt_r,  low_cnt_nxt;
  logic [CW-1:0] high_lat_r, high_lat_nxt;
  logic          last_low_r, last_low_nxt;

  // a rising edge completes a period
  assign emit      = level && last_low_r;
  assign high_done = high_lat_r;
  assign low_done  = low_cnt_r;

  // count the current level, then act on the edge
  always_comb begin
    high_cnt_nxt = high_cnt_r;
    low_cnt_nxt  = low_cnt_r;
    high_lat_nxt = high_lat_r;
    last_low_nxt = last_low_r;
    if (accept) begin
      if (level) begin
        high_cnt_nxt = (high_cnt_r == '1) ? high_cnt_r : high_cnt_r + CW'(1);
        if (last_low_r) begin
          last_low_nxt = 1'b0;
          low_cnt_nxt  = '0;
        end
      end else begin
        low_cnt_nxt = (low_cnt_r == '1) ? low_cnt_r : low_cnt_r + CW'(1);
        if (!last_low_r) begin
          high_lat_nxt = high_cnt_r;
          last_low_nxt = 1'b1;
          high_cnt_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_cnt_r <= '0;
      low_cnt_r  <= '0;
      high_lat_r <= '0;
      last_low_r <= 1'b0;
    end else begin
      high_cnt_r <= high_cnt_nxt;
      low_cnt_r  <= low_cnt_nxt;
      high_lat_r <= high_lat_nxt;
      last_low_r <= last_low_nxt;
    end
  end

endmodule

@@ src/pdfm_div.sv @@
// ----------------------------------------------------------------------------
// pdfm_div
// Bit-serial restoring divider: one quotient bit per cycle, NW quotient bits.
// ----------------------------------------------------------------------------
module pdfm_div #(
  parameter int NW = 24,
  parameter int DW = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  output logic [NW-1:0]       quot,
  output pdfm_pkg::div_stat_t st
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    num_r, num_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             take;

  // bring down one numerator bit and try the subtraction
  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = !diff[DW];

  // numerator bits shift out at the top, quotient bits in at the bottom
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = CNT_W'(NW);
    end else if (cnt_r != '0) begin
      num_nxt  = {num_r[NW-2:0], take};
      rem_nxt  = take ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot    = num_r;
  assign st.busy = (cnt_r != '0);
  assign st.done = done_r;

endmodule
